### rtl/par_pkg.sv
`default_nettype none

package par_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_RUN   = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

    localparam int COORD_W = 32;
    localparam int ANGLE_W = 16;
    localparam int ANG_W   = ANGLE_W + 1;
    localparam int TRIG_W  = 34;
    localparam int FRAC_W  = 30;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int MAG_W   = 13;

    localparam logic signed [ANG_W-1:0] TURN         = 17'sd23040;
    localparam logic signed [ANG_W-1:0] HALF_TURN    = 17'sd11520;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 17'sd5760;

    // theta = mag*QUOT + (mag*REM + 5760) / 11520, with 11520 = 2^8 * 45
    localparam longint PI_Q30        = 64'd3373259426;
    localparam longint RAD_QUOT      = PI_Q30 / 11520;
    localparam longint RAD_REM       = PI_Q30 % 11520;
    localparam int     MQ_W          = 32;
    localparam int     MR_W          = 26;
    localparam int     DIV_SHIFT     = 8;
    localparam int     DIV_ODD       = 45;
    localparam int     V_W           = MR_W - DIV_SHIFT;
    localparam int     RECIP_SHIFT   = 24;
    localparam longint RECIP         = (64'd1 << RECIP_SHIFT) / DIV_ODD + 1;
    localparam int     RECIP_W       = 19;
    localparam int     QP_W          = V_W + RECIP_W;
    localparam int     QD_W          = 12;
    localparam longint THETA_MAX     = (PI_Q30 + 1) / 2;
    localparam longint GAIN_Q30      = 64'd652032874;
    localparam longint ROUND_BIAS    = 64'd1 << (FRAC_W - 1);

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    // rot[0] about x, rot[1] about y, rot[2] about z
    typedef struct packed {
        logic [2:0] rot;
        point_t     pt;
    } item_t;

    function automatic logic signed [TRIG_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [TRIG_W-1:0] v;
        case (idx)
            5'd0:    v = TRIG_W'(32'h3243F6A8);
            5'd1:    v = TRIG_W'(32'h1DAC6705);
            5'd2:    v = TRIG_W'(32'h0FADBAFC);
            5'd3:    v = TRIG_W'(32'h07F56EA6);
            5'd4:    v = TRIG_W'(32'h03FEAB76);
            5'd5:    v = TRIG_W'(32'h01FFD55B);
            5'd6:    v = TRIG_W'(32'h00FFFAAA);
            5'd7:    v = TRIG_W'(32'h007FFF55);
            5'd8:    v = TRIG_W'(32'h003FFFEA);
            5'd9:    v = TRIG_W'(32'h001FFFFD);
            5'd10:   v = TRIG_W'(32'h000FFFFF);
            5'd11:   v = TRIG_W'(32'h0007FFFF);
            5'd12:   v = TRIG_W'(32'h0003FFFF);
            5'd13:   v = TRIG_W'(32'h0001FFFF);
            5'd14:   v = TRIG_W'(32'h0000FFFF);
            5'd15:   v = TRIG_W'(32'h00007FFF);
            5'd16:   v = TRIG_W'(32'h00003FFF);
            5'd17:   v = TRIG_W'(32'h00001FFF);
            5'd18:   v = TRIG_W'(32'h00000FFF);
            5'd19:   v = TRIG_W'(32'h000007FF);
            5'd20:   v = TRIG_W'(32'h000003FF);
            5'd21:   v = TRIG_W'(32'h000001FF);
            5'd22:   v = TRIG_W'(32'h000000FF);
            5'd23:   v = TRIG_W'(32'h0000007F);
            5'd24:   v = TRIG_W'(32'h0000003F);
            5'd25:   v = TRIG_W'(32'h0000001F);
            5'd26:   v = TRIG_W'(32'h0000000F);
            5'd27:   v = TRIG_W'(32'h00000008);
            5'd28:   v = TRIG_W'(32'h00000004);
            5'd29:   v = TRIG_W'(32'h00000002);
            5'd30:   v = TRIG_W'(32'h00000001);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/par_rot_stage.sv
`default_nettype none

module par_rot_stage (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                ce,
    input  par_pkg::axis_t                      axis,
    input  logic                                in_valid,
    input  par_pkg::item_t                      in_item,
    input  logic signed [par_pkg::COORD_W-1:0]  in_c,
    input  logic signed [par_pkg::COORD_W-1:0]  in_s,
    output logic                                out_valid,
    output par_pkg::item_t                      out_item,
    output logic signed [par_pkg::COORD_W-1:0]  out_c,
    output logic signed [par_pkg::COORD_W-1:0]  out_s
);
    import par_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sh7FFFFFFF);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    function automatic logic signed [COORD_W-1:0] round_sat(
        input logic signed [SUM_W-1:0] sum
    );
        logic signed [SUM_W-1:0] shifted;
        logic signed [COORD_W-1:0] r;
        shifted = (sum + SUM_W'(ROUND_BIAS)) >>> FRAC_W;
        if (shifted > SAT_HI)
        begin
            r = SAT_HI[COORD_W-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            r = SAT_LO[COORD_W-1:0];
        end
        else
        begin
            r = shifted[COORD_W-1:0];
        end
        return r;
    endfunction

    logic signed [COORD_W-1:0] u;
    logic signed [COORD_W-1:0] v;
    logic                      en;

    logic                      a_valid_reg;
    item_t                     a_item_reg;
    logic signed [COORD_W-1:0] a_c_reg;
    logic signed [COORD_W-1:0] a_s_reg;
    logic                      a_en_reg;
    logic signed [PROD_W-1:0]  a_uc_reg;
    logic signed [PROD_W-1:0]  a_vs_reg;
    logic signed [PROD_W-1:0]  a_us_reg;
    logic signed [PROD_W-1:0]  a_vc_reg;

    logic signed [COORD_W-1:0] nu;
    logic signed [COORD_W-1:0] nv;
    item_t                     b_item_next;

    logic                      b_valid_reg;
    item_t                     b_item_reg;
    logic signed [COORD_W-1:0] b_c_reg;
    logic signed [COORD_W-1:0] b_s_reg;

    // (u, v) -> (u*c - v*s, u*s + v*c)
    always_comb
    begin
        case (axis)
            AXIS_X:
            begin
                u  = in_item.pt.y;
                v  = in_item.pt.z;
                en = in_item.rot[0];
            end
            AXIS_Y:
            begin
                u  = in_item.pt.z;
                v  = in_item.pt.x;
                en = in_item.rot[1];
            end
            default:
            begin
                u  = in_item.pt.x;
                v  = in_item.pt.y;
                en = in_item.rot[2];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_item_reg <= in_item;
            a_c_reg    <= in_c;
            a_s_reg    <= in_s;
            a_en_reg   <= en;
            a_uc_reg   <= PROD_W'(u) * PROD_W'(in_c);
            a_vs_reg   <= PROD_W'(v) * PROD_W'(in_s);
            a_us_reg   <= PROD_W'(u) * PROD_W'(in_s);
            a_vc_reg   <= PROD_W'(v) * PROD_W'(in_c);
        end
    end

    assign nu = round_sat(SUM_W'(a_uc_reg) - SUM_W'(a_vs_reg));
    assign nv = round_sat(SUM_W'(a_us_reg) + SUM_W'(a_vc_reg));

    always_comb
    begin
        b_item_next = a_item_reg;
        if (a_en_reg)
        begin
            case (axis)
                AXIS_X:
                begin
                    b_item_next.pt.y = nu;
                    b_item_next.pt.z = nv;
                end
                AXIS_Y:
                begin
                    b_item_next.pt.z = nu;
                    b_item_next.pt.x = nv;
                end
                default:
                begin
                    b_item_next.pt.x = nu;
                    b_item_next.pt.y = nv;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            b_item_reg <= b_item_next;
            b_c_reg    <= a_c_reg;
            b_s_reg    <= a_s_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;
    assign out_c     = b_c_reg;
    assign out_s     = b_s_reg;

endmodule

`default_nettype wire

### rtl/point_axis_rotation_core.sv
// Path: angle front end, CORDIC stages, sine/cosine register, x, y and z rotations.
// Throughput: one item per cycle; the angle front end, one CORDIC stage per step
// and two multiply/round stages per axis all advance together.
// A stall on the output holds the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) clears all stage valid bits; data registers are not reset.
`default_nettype none

module point_axis_rotation_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], angle_deg[111:96],
    // rot_x[112], rot_y[113], rot_z[114], zero[119:115]
    input  logic [119:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [95:0]   m_axis_tdata
);
    import par_pkg::*;

    logic                      ce;
    item_t                     in_item;
    logic signed [ANG_W-1:0]   ang_ext;
    logic signed [ANG_W-1:0]   ang_mod;
    logic signed [ANG_W-1:0]   ang_half;
    logic signed [ANG_W-1:0]   ang_red;
    logic                      flip_next;
    logic signed [ANG_W-1:0]   ang_abs;

    logic                      s1_valid_reg;
    item_t                     s1_item_reg;
    logic [MAG_W-1:0]          s1_mag_reg;
    logic                      s1_neg_reg;
    logic                      s1_flip_reg;

    logic                      s2_valid_reg;
    item_t                     s2_item_reg;
    logic [MQ_W-1:0]           s2_mq_reg;
    logic [MR_W-1:0]           s2_mr_reg;
    logic                      s2_neg_reg;
    logic                      s2_flip_reg;

    logic [QP_W-1:0]           qp;
    logic                      s3_valid_reg;
    item_t                     s3_item_reg;
    logic [MQ_W-1:0]           s3_mq_reg;
    logic [QD_W-1:0]           s3_qd_reg;
    logic                      s3_neg_reg;
    logic                      s3_flip_reg;

    logic signed [TRIG_W-1:0]  theta_next;

    logic                      cv_reg [0:CORDIC_RUN];
    item_t                     ci_reg [0:CORDIC_RUN];
    logic                      cf_reg [0:CORDIC_RUN];
    logic signed [TRIG_W-1:0]  cx_reg [0:CORDIC_RUN];
    logic signed [TRIG_W-1:0]  cy_reg [0:CORDIC_RUN];
    logic signed [TRIG_W-1:0]  cz_reg [0:CORDIC_RUN];

    logic signed [COORD_W-1:0] c_next;
    logic signed [COORD_W-1:0] s_next;
    logic                      sc_valid_reg;
    item_t                     sc_item_reg;
    logic signed [COORD_W-1:0] sc_c_reg;
    logic signed [COORD_W-1:0] sc_s_reg;

    logic                      rx_valid;
    item_t                     rx_item;
    logic signed [COORD_W-1:0] rx_c;
    logic signed [COORD_W-1:0] rx_s;
    logic                      ry_valid;
    item_t                     ry_item;
    logic signed [COORD_W-1:0] ry_c;
    logic signed [COORD_W-1:0] ry_s;
    logic                      rz_valid;
    item_t                     rz_item;

    assign ce            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;

    assign in_item.pt.x = s_axis_tdata[31:0];
    assign in_item.pt.y = s_axis_tdata[63:32];
    assign in_item.pt.z = s_axis_tdata[95:64];
    assign in_item.rot  = s_axis_tdata[114:112];

    // angle into [-90, 90] degrees, flip marks a half-turn shift
    always_comb
    begin
        ang_ext = {s_axis_tdata[111], s_axis_tdata[111:96]};
        if (ang_ext < -TURN)
        begin
            ang_mod = ang_ext + TURN + TURN;
        end
        else if (ang_ext < 0)
        begin
            ang_mod = ang_ext + TURN;
        end
        else if (ang_ext >= TURN)
        begin
            ang_mod = ang_ext - TURN;
        end
        else
        begin
            ang_mod = ang_ext;
        end
        ang_half = (ang_mod > HALF_TURN) ? ang_mod - TURN : ang_mod;
        if (ang_half > QUARTER_TURN)
        begin
            ang_red   = ang_half - HALF_TURN;
            flip_next = 1'b1;
        end
        else if (ang_half < -QUARTER_TURN)
        begin
            ang_red   = ang_half + HALF_TURN;
            flip_next = 1'b1;
        end
        else
        begin
            ang_red   = ang_half;
            flip_next = 1'b0;
        end
        ang_abs = ang_red[ANG_W-1] ? -ang_red : ang_red;
    end

    assign qp = QP_W'(s2_mr_reg[MR_W-1:DIV_SHIFT]) * QP_W'(RECIP);

    always_comb
    begin
        theta_next = TRIG_W'(s3_mq_reg) + TRIG_W'(s3_qd_reg);
        if (s3_neg_reg)
        begin
            theta_next = -theta_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            cv_reg[0]    <= 1'b0;
        end
        else if (ce)
        begin
            s1_valid_reg <= s_axis_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            cv_reg[0]    <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s1_item_reg <= in_item;
            s1_mag_reg  <= ang_abs[MAG_W-1:0];
            s1_neg_reg  <= ang_red[ANG_W-1];
            s1_flip_reg <= flip_next;

            s2_item_reg <= s1_item_reg;
            s2_mq_reg   <= MQ_W'(s1_mag_reg) * MQ_W'(RAD_QUOT);
            s2_mr_reg   <= MR_W'(s1_mag_reg) * MR_W'(RAD_REM) + MR_W'(QUARTER_TURN);
            s2_neg_reg  <= s1_neg_reg;
            s2_flip_reg <= s1_flip_reg;

            s3_item_reg <= s2_item_reg;
            s3_mq_reg   <= s2_mq_reg;
            s3_qd_reg   <= qp[RECIP_SHIFT +: QD_W];
            s3_neg_reg  <= s2_neg_reg;
            s3_flip_reg <= s2_flip_reg;

            ci_reg[0]   <= s3_item_reg;
            cf_reg[0]   <= s3_flip_reg;
            cx_reg[0]   <= TRIG_W'(GAIN_Q30);
            cy_reg[0]   <= '0;
            cz_reg[0]   <= theta_next;
        end
    end

    for (genvar k = 0; k < CORDIC_RUN; k++)
    begin : g_cordic
        logic signed [TRIG_W-1:0] dx;
        logic signed [TRIG_W-1:0] dy;
        logic signed [TRIG_W-1:0] at;
        logic signed [TRIG_W-1:0] x_next;
        logic signed [TRIG_W-1:0] y_next;
        logic signed [TRIG_W-1:0] z_next;

        assign dx = cy_reg[k] >>> k;
        assign dy = cx_reg[k] >>> k;
        assign at = atan_q30(5'(k));

        always_comb
        begin
            if (!cz_reg[k][TRIG_W-1])
            begin
                x_next = cx_reg[k] - dx;
                y_next = cy_reg[k] + dy;
                z_next = cz_reg[k] - at;
            end
            else
            begin
                x_next = cx_reg[k] + dx;
                y_next = cy_reg[k] - dy;
                z_next = cz_reg[k] + at;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[k+1] <= 1'b0;
            end
            else if (ce)
            begin
                cv_reg[k+1] <= cv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                ci_reg[k+1] <= ci_reg[k];
                cf_reg[k+1] <= cf_reg[k];
                cx_reg[k+1] <= x_next;
                cy_reg[k+1] <= y_next;
                cz_reg[k+1] <= z_next;
            end
        end
    end

    always_comb
    begin
        if (cf_reg[CORDIC_RUN])
        begin
            c_next = COORD_W'(-cx_reg[CORDIC_RUN]);
            s_next = COORD_W'(-cy_reg[CORDIC_RUN]);
        end
        else
        begin
            c_next = COORD_W'(cx_reg[CORDIC_RUN]);
            s_next = COORD_W'(cy_reg[CORDIC_RUN]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            sc_valid_reg <= cv_reg[CORDIC_RUN];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sc_item_reg <= ci_reg[CORDIC_RUN];
            sc_c_reg    <= c_next;
            sc_s_reg    <= s_next;
        end
    end

    par_rot_stage u_rot_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .axis      (AXIS_X),
        .in_valid  (sc_valid_reg),
        .in_item   (sc_item_reg),
        .in_c      (sc_c_reg),
        .in_s      (sc_s_reg),
        .out_valid (rx_valid),
        .out_item  (rx_item),
        .out_c     (rx_c),
        .out_s     (rx_s)
    );

    par_rot_stage u_rot_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .axis      (AXIS_Y),
        .in_valid  (rx_valid),
        .in_item   (rx_item),
        .in_c      (rx_c),
        .in_s      (rx_s),
        .out_valid (ry_valid),
        .out_item  (ry_item),
        .out_c     (ry_c),
        .out_s     (ry_s)
    );

    par_rot_stage u_rot_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .axis      (AXIS_Z),
        .in_valid  (ry_valid),
        .in_item   (ry_item),
        .in_c      (ry_c),
        .in_s      (ry_s),
        .out_valid (rz_valid),
        .out_item  (rz_item),
        .out_c     (),
        .out_s     ()
    );

    assign m_axis_tvalid = rz_valid;
    assign m_axis_tdata  = {rz_item.pt.z, rz_item.pt.y, rz_item.pt.x};

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> s1_valid_reg)
        else $error("accepted item did not enter the pipeline");

    a_reduced_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> s1_mag_reg <= MAG_W'(QUARTER_TURN))
        else $error("reduced angle outside quarter turn");

    a_theta_range: assert property (@(posedge clk) disable iff (!rst_n)
        cv_reg[0] |-> (cz_reg[0] <= TRIG_W'(THETA_MAX)) && (cz_reg[0] >= -TRIG_W'(THETA_MAX)))
        else $error("CORDIC start angle beyond pi/2");

    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        sc_valid_reg |-> (sc_c_reg <= 32'sh40100000) && (sc_c_reg >= -32'sh40100000)
                      && (sc_s_reg <= 32'sh40100000) && (sc_s_reg >= -32'sh40100000))
        else $error("sine or cosine out of unit range");

endmodule

`default_nettype wire
